// ===== design/avtp_audio_sample_extractor_top_assert.svh =====
// assertion macros for the audio sample extractor
// every use sits inside a module that has aclk and aresetn
`ifndef AVTP_AUDIO_SAMPLE_EXTRACTOR_TOP_ASSERT_SVH
`define AVTP_AUDIO_SAMPLE_EXTRACTOR_TOP_ASSERT_SVH

// when ante holds in a cycle, cons must hold in the same cycle
`define ASE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold outside reset
`define ASE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ===== design/avtp_ase_pkg.sv =====
// ----------------------------------------------------------------------------
// avtp_ase_pkg
// Shared constants and types of the audio sample extractor: frame layout,
// ethertypes, packet geometry and the entry passed from front to back.
// ----------------------------------------------------------------------------
package avtp_ase_pkg;

    // packet geometry
    localparam int FRAMES_PER_PACKET = 6;
    localparam int NUM_CHANNELS      = 2;
    localparam int TOTAL_SAMPLES     = FRAMES_PER_PACKET * NUM_CHANNELS;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FR_W = (FRAMES_PER_PACKET > 1) ? $clog2(FRAMES_PER_PACKET) : 1;

    // ethertypes
    localparam logic [15:0] TYPE_AVTP = 16'h22F0;
    localparam logic [15:0] TYPE_VLAN = 16'h8100;

    // byte positions within the frame
    localparam int OFF_W = 7;
    localparam logic [OFF_W-1:0] OFFSET_MAX = 7'd127;

    localparam int ETH_HDR_BYTES    = 18;
    localparam int AVTP_PART1_BYTES = 4;
    localparam int ID_BYTES         = 8;
    localparam int AVTP_PART2_BYTES = 10;
    localparam int CIP_HDR_BYTES    = 10;
    localparam int TAG_BYTES        = 4;

    localparam int TAGGED_ID_INT   = ETH_HDR_BYTES + AVTP_PART1_BYTES;
    localparam int TAGGED_DATA_INT = TAGGED_ID_INT + ID_BYTES + AVTP_PART2_BYTES
                                     + CIP_HDR_BYTES;

    localparam logic [OFF_W-1:0] POS_TYPE_HI   = 7'd12;
    localparam logic [OFF_W-1:0] POS_TYPE_LO   = 7'd13;
    localparam logic [OFF_W-1:0] POS_INNER_HI  = 7'd16;
    localparam logic [OFF_W-1:0] POS_INNER_LO  = 7'd17;
    localparam logic [OFF_W-1:0] TAGGED_ID_POS   = OFF_W'(TAGGED_ID_INT);
    localparam logic [OFF_W-1:0] UNTAGGED_ID_POS = OFF_W'(TAGGED_ID_INT - TAG_BYTES);
    localparam logic [OFF_W-1:0] TAGGED_DATA_POS = OFF_W'(TAGGED_DATA_INT);
    localparam logic [OFF_W-1:0] UNTAGGED_DATA_POS = OFF_W'(TAGGED_DATA_INT - TAG_BYTES);
    localparam logic [OFF_W-1:0] ID_LEN = OFF_W'(ID_BYTES);

    // byte lane within a sample word
    localparam logic [1:0] LANE_LABEL = 2'd0;
    localparam logic [1:0] LANE_LAST  = 2'd3;

    // small queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one sample byte with its classification
    typedef struct packed {
        logic [7:0]      data_byte;
        logic            emit;
        logic            channel;
        logic [2:0]      frame_index;
        logic            last_sample;
    } ase_op_t;

endpackage

// ===== design/avtp_audio_sample_extractor_top.sv =====
// Path: the edge that accepts a sample's last byte writes it into the byte
// queue; from there the finished sample is loaded into the output register,
// which drives m_valid, once that register is free.
// Throughput: one byte per cycle; the front takes a byte whenever the
// two-entry byte queue has room, which only fills while an output waits.
// Reset: synchronous active-low aresetn clears the header tracker, the queue,
// the output valid and the stream ID register (to zero).
// ----------------------------------------------------------------------------
// avtp_audio_sample_extractor_top
// Pulls two-channel audio samples out of stream packets carried in Ethernet
// frames that arrive one byte per item.
// ----------------------------------------------------------------------------
module avtp_audio_sample_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sample_word,
    output logic        m_channel,
    output logic [2:0]  m_frame_index,
    output logic        m_last_sample
);
    import avtp_ase_pkg::*;

    `include "avtp_audio_sample_extractor_top_assert.svh"

    logic    q_push;
    logic    q_ready;
    ase_op_t q_push_entry;
    logic    q_pop;
    logic    q_valid;
    ase_op_t q_pop_entry;

    assign s_ready = q_ready;

    // header parsing and byte classification
    avtp_ase_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_data_byte    (s_data_byte),
        .s_end_of_frame (s_end_of_frame),
        .q_ready        (q_ready),
        .q_push         (q_push),
        .q_entry        (q_push_entry)
    );

    // decoupling queue
    avtp_ase_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_pop_entry)
    );

    // sample assembly and output
    avtp_ase_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_pop_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_word (m_sample_word),
        .m_channel     (m_channel),
        .m_frame_index (m_frame_index),
        .m_last_sample (m_last_sample)
    );

    // checks
    `ASE_ASSERT_IMPLIES(a_last_is_final_slot, m_valid && m_last_sample,
        m_channel == 1'(NUM_CHANNELS - 1) && m_frame_index == 3'(FRAMES_PER_PACKET - 1),
        "last sample not on the final channel and frame")
    `ASE_ASSERT_IMPLIES(a_stall_only_when_output_held, !s_ready, m_valid,
        "input stalled while no sample is waiting at the output")
    `ASE_ASSERT_NEVER(a_low_byte_zero, m_valid && m_sample_word[7:0] != 8'h00,
        "sample word low byte not zero")

endmodule

// ===== design/avtp_ase_front.sv =====
// ----------------------------------------------------------------------------
// avtp_ase_front
// Accepts frame bytes, tracks the header, checks the stream ID and marks
// each sample byte for the back end as a shift or a shift-and-emit.
// ----------------------------------------------------------------------------
module avtp_ase_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [63:0]            cfg_wdata,
    input  logic                   s_valid,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_end_of_frame,
    input  logic                   q_ready,
    output logic                   q_push,
    output avtp_ase_pkg::ase_op_t  q_entry
);
    import avtp_ase_pkg::*;

    logic [63:0]      stream_id_reg;
    logic [OFF_W-1:0] byte_offset_reg, byte_offset_next;
    logic [7:0]       outer_hi_reg, outer_hi_next;
    logic [7:0]       inner_hi_reg, inner_hi_next;
    logic             is_tagged_reg, is_tagged_next;
    logic             dropping_reg, dropping_next;
    logic             id_matches_reg, id_matches_next;
    logic [1:0]       lane_reg, lane_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [FR_W-1:0]  fr_reg, fr_next;
    logic             done_reg, done_next;

    logic             accept;
    logic             active;
    logic [OFF_W-1:0] id_pos;
    logic [OFF_W-1:0] data_pos;
    logic [OFF_W-1:0] id_rel;
    logic [2:0]       id_byte_sel;
    logic [7:0]       id_want;
    logic             in_id;
    logic             in_data;
    logic             last_word;

    assign accept = s_valid && q_ready;

    // configured stream ID
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_id_reg <= '0;
        end else if (cfg_we) begin
            stream_id_reg <= cfg_wdata;
        end
    end

    // byte classification
    always_comb begin
        active      = (byte_offset_reg != OFFSET_MAX) && !dropping_reg;
        id_pos      = is_tagged_reg ? TAGGED_ID_POS : UNTAGGED_ID_POS;
        data_pos    = is_tagged_reg ? TAGGED_DATA_POS : UNTAGGED_DATA_POS;
        id_rel      = byte_offset_reg - id_pos;
        id_byte_sel = 3'd7 - id_rel[2:0];
        id_want     = stream_id_reg[{id_byte_sel, 3'b000} +: 8];
        in_id       = active && (byte_offset_reg >= id_pos)
                      && (byte_offset_reg < id_pos + ID_LEN);
        in_data     = active && (byte_offset_reg >= data_pos) && !done_reg;
        last_word   = (ch_reg == CH_W'(NUM_CHANNELS - 1))
                      && (fr_reg == FR_W'(FRAMES_PER_PACKET - 1));
    end

    // queue push: every data byte past the label byte
    always_comb begin
        q_push              = accept && in_data && (lane_reg != LANE_LABEL);
        q_entry.data_byte   = s_data_byte;
        q_entry.emit        = (lane_reg == LANE_LAST) && id_matches_reg;
        q_entry.channel     = ch_reg[0];
        q_entry.frame_index = 3'(fr_reg);
        q_entry.last_sample = last_word;
    end

    // header and position tracking
    always_comb begin
        byte_offset_next = byte_offset_reg;
        outer_hi_next    = outer_hi_reg;
        inner_hi_next    = inner_hi_reg;
        is_tagged_next   = is_tagged_reg;
        dropping_next    = dropping_reg;
        id_matches_next  = id_matches_reg;
        lane_next        = lane_reg;
        ch_next          = ch_reg;
        fr_next          = fr_reg;
        done_next        = done_reg;

        if (accept) begin
            if (active) begin
                // outer ethertype
                if (byte_offset_reg == POS_TYPE_HI) begin
                    outer_hi_next = s_data_byte;
                end
                if (byte_offset_reg == POS_TYPE_LO) begin
                    if ({outer_hi_reg, s_data_byte} == TYPE_VLAN) begin
                        is_tagged_next = 1'b1;
                    end else if ({outer_hi_reg, s_data_byte} != TYPE_AVTP) begin
                        dropping_next = 1'b1;
                    end
                end
                // inner ethertype behind the tag
                if (is_tagged_reg && byte_offset_reg == POS_INNER_HI) begin
                    inner_hi_next = s_data_byte;
                end
                if (is_tagged_reg && byte_offset_reg == POS_INNER_LO
                    && {inner_hi_reg, s_data_byte} != TYPE_AVTP) begin
                    dropping_next = 1'b1;
                end
            end
            // stream ID compare
            if (in_id && id_want != s_data_byte) begin
                id_matches_next = 1'b0;
            end
            // sample word lanes and sample index
            if (in_data) begin
                lane_next = lane_reg + 2'd1;
                if (lane_reg == LANE_LAST) begin
                    if (last_word) begin
                        done_next = 1'b1;
                    end
                    if (ch_reg == CH_W'(NUM_CHANNELS - 1)) begin
                        ch_next = '0;
                        fr_next = fr_reg + FR_W'(1);
                    end else begin
                        ch_next = ch_reg + CH_W'(1);
                    end
                end
            end
            if (byte_offset_reg != OFFSET_MAX) begin
                byte_offset_next = byte_offset_reg + OFF_W'(1);
            end
            // end of frame returns everything to idle
            if (s_end_of_frame) begin
                byte_offset_next = '0;
                outer_hi_next    = '0;
                inner_hi_next    = '0;
                is_tagged_next   = 1'b0;
                dropping_next    = 1'b0;
                id_matches_next  = 1'b1;
                lane_next        = LANE_LABEL;
                ch_next          = '0;
                fr_next          = '0;
                done_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg <= '0;
            outer_hi_reg    <= '0;
            inner_hi_reg    <= '0;
            is_tagged_reg   <= 1'b0;
            dropping_reg    <= 1'b0;
            id_matches_reg  <= 1'b1;
            lane_reg        <= LANE_LABEL;
            ch_reg          <= '0;
            fr_reg          <= '0;
            done_reg        <= 1'b0;
        end else begin
            byte_offset_reg <= byte_offset_next;
            outer_hi_reg    <= outer_hi_next;
            inner_hi_reg    <= inner_hi_next;
            is_tagged_reg   <= is_tagged_next;
            dropping_reg    <= dropping_next;
            id_matches_reg  <= id_matches_next;
            lane_reg        <= lane_next;
            ch_reg          <= ch_next;
            fr_reg          <= fr_next;
            done_reg        <= done_next;
        end
    end

endmodule

// ===== design/avtp_ase_queue.sv =====
// ----------------------------------------------------------------------------
// avtp_ase_queue
// Small first-in first-out queue of classified sample bytes between the
// front and the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module avtp_ase_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  avtp_ase_pkg::ase_op_t  push_entry,
    output logic                   push_ready,
    input  logic                   pop,
    output logic                   pop_valid,
    output avtp_ase_pkg::ase_op_t  pop_entry
);
    import avtp_ase_pkg::*;

    ase_op_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/avtp_ase_back.sv =====
// ----------------------------------------------------------------------------
// avtp_ase_back
// Assembles the 24-bit sample from queued bytes and holds each finished
// sample in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module avtp_ase_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  avtp_ase_pkg::ase_op_t  q_entry,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_sample_word,
    output logic                   m_channel,
    output logic [2:0]             m_frame_index,
    output logic                   m_last_sample
);
    import avtp_ase_pkg::*;

    logic [15:0] acc_reg, acc_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_sample_word_reg;
    logic        m_channel_reg;
    logic [2:0]  m_frame_index_reg;
    logic        m_last_sample_reg;
    logic        load_out;

    // shifts always drain, a sample waits for a free output register
    assign q_pop    = q_valid && (!q_entry.emit || !m_valid_reg || m_ready);
    assign load_out = q_pop && q_entry.emit;

    always_comb begin
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            acc_next = {acc_reg[7:0], q_entry.data_byte};
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // sample assembly and output payload
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (load_out) begin
            m_sample_word_reg <= {acc_reg, q_entry.data_byte, 8'h00};
            m_channel_reg     <= q_entry.channel;
            m_frame_index_reg <= q_entry.frame_index;
            m_last_sample_reg <= q_entry.last_sample;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_word = m_sample_word_reg;
    assign m_channel     = m_channel_reg;
    assign m_frame_index = m_frame_index_reg;
    assign m_last_sample = m_last_sample_reg;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the audio sample extractor. Ethernet frames are
// built byte by byte (tagged, untagged, wrong ethertypes, wrong stream IDs,
// short, long and random frames) and fed through the byte channel while a
// parser model tracks the header and predicts samples where no count is typed.
// Samples coming out of the block are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // frame layout and packet geometry
    localparam logic [15:0] ETH_TYPE_AVTP   = 16'h22F0;
    localparam logic [15:0] ETH_TYPE_VLAN   = 16'h8100;
    localparam int POS_TYPE_HI        = 12;
    localparam int POS_TYPE_LO        = 13;
    localparam int POS_INNER_HI       = 16;
    localparam int POS_INNER_LO       = 17;
    localparam int TAGGED_ID_AT       = 22;
    localparam int UNTAGGED_ID_AT     = 18;
    localparam int TAGGED_DATA_AT     = 50;
    localparam int UNTAGGED_DATA_AT   = 46;
    localparam int ID_LEN             = 8;
    localparam int OFFSET_LIMIT       = 127;
    localparam int CHANNELS           = 2;
    localparam int SAMPLES_PER_PACKET = 12;

    // run control
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_BYTES    = 40;
    localparam int MAX_REPORTS    = 10;

    typedef enum {
        ROW_TAGGED, ROW_UNTAGGED, ROW_BAD_OUTER, ROW_BAD_INNER, ROW_NOISE, ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic [31:0] word;
        logic        ch;
        logic [2:0]  fidx;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [6:0]  offset;
        logic [15:0] outer;
        logic [15:0] inner;
        logic        vlan;
        logic        dropping;
        logic        id_ok;
        logic [23:0] acc;
    } parse_state_t;

    localparam parse_state_t HDR_CLEAR = '{offset: '0, outer: '0, inner: '0, vlan: 1'b0,
                                           dropping: 1'b0, id_ok: 1'b1, acc: '0};

    // one directed step: a frame, or a stream ID write when kind is ROW_CFG
    typedef struct {
        row_kind_t   kind;
        int          len;       // 0 means a complete packet
        int          fill;      // byte for the sample area, -1 for random
        bit          id_bad;
        logic [63:0] cfg_val;
        int          n_exp;     // typed sample count, -1 to use the parser model
        logic [31:0] word_exp;
    } test_row_t;

    test_row_t directed_rows [17] = '{
        // kind           len  fill  bad  cfg                    n   word
        '{ROW_TAGGED,      0,  0,    0,   64'h0,                 12, 32'h0000_0000},
        '{ROW_TAGGED,      0,  255,  0,   64'h0,                 12, 32'hFFFF_FF00},
        '{ROW_UNTAGGED,    0,  255,  0,   64'h0,                 12, 32'hFFFF_FF00},
        '{ROW_BAD_OUTER,   0,  255,  0,   64'h0,                 0,  32'h0},
        '{ROW_BAD_INNER,   0,  255,  0,   64'h0,                 0,  32'h0},
        '{ROW_TAGGED,      0,  255,  1,   64'h0,                 0,  32'h0},
        '{ROW_CFG,         0,  0,    0,   64'hFFFF_FFFF_FFFF_FFFF, 0, 32'h0},
        '{ROW_UNTAGGED,    0,  255,  1,   64'h0,                 0,  32'h0},
        '{ROW_CFG,         0,  0,    0,   64'h0123_4567_89AB_CDEF, 0, 32'h0},
        '{ROW_TAGGED,      72, -1,   0,   64'h0,                 -1, 32'h0},
        '{ROW_UNTAGGED,    93, -1,   0,   64'h0,                 -1, 32'h0},
        '{ROW_TAGGED,      140, -1,  0,   64'h0,                 -1, 32'h0},
        '{ROW_NOISE,       1,  -1,   0,   64'h0,                 0,  32'h0},
        '{ROW_UNTAGGED,    14, -1,   0,   64'h0,                 0,  32'h0},
        '{ROW_NOISE,       120, -1,  0,   64'h0,                 -1, 32'h0},
        '{ROW_CFG,         0,  0,    0,   64'h0,                 0,  32'h0},
        '{ROW_UNTAGGED,    0,  0,    0,   64'h0,                 12, 32'h0000_0000}
    };

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [63:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = '0;
    logic        s_end_of_frame = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_sample_word;
    logic        m_channel;
    logic [2:0]  m_frame_index;
    logic        m_last_sample;

    parse_state_t hdr           = HDR_CLEAR;
    logic [63:0]  stream_id_cfg = '0;
    sample_t      pending_samples[$];
    logic [8:0]   frame_q[$];
    int           mismatches     = 0;
    int           bytes_accepted = 0;
    int           stall_cycles   = 0;
    bit           tx_gaps        = 1'b0;
    bit           rx_gaps        = 1'b0;
    bit           rx_hold        = 1'b0;

    avtp_audio_sample_extractor_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_word  (m_sample_word),
        .m_channel      (m_channel),
        .m_frame_index  (m_frame_index),
        .m_last_sample  (m_last_sample)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser model: consume one byte, return 1 when it completes a sample
    function automatic bit sample_from_byte(input logic [7:0] b, input bit eof,
                                            output sample_t s);
        int  pos;
        int  id_pos;
        int  data_pos;
        int  rel;
        int  idx;
        int  lane;
        bit  hit;
        pos = hdr.offset;
        hit = 1'b0;
        s   = '0;
        if (pos < OFFSET_LIMIT && !hdr.dropping) begin
            id_pos   = hdr.vlan ? TAGGED_ID_AT : UNTAGGED_ID_AT;
            data_pos = hdr.vlan ? TAGGED_DATA_AT : UNTAGGED_DATA_AT;
            if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) begin
                hdr.outer = {hdr.outer[7:0], b};
                if (pos == POS_TYPE_LO) begin
                    if (hdr.outer == ETH_TYPE_VLAN)
                        hdr.vlan = 1'b1;
                    else if (hdr.outer != ETH_TYPE_AVTP)
                        hdr.dropping = 1'b1;
                end
            end else if (pos > POS_TYPE_LO) begin
                // inner ethertype only exists behind a vlan tag
                if (hdr.vlan && (pos == POS_INNER_HI || pos == POS_INNER_LO)) begin
                    hdr.inner = {hdr.inner[7:0], b};
                    if (pos == POS_INNER_LO && hdr.inner != ETH_TYPE_AVTP)
                        hdr.dropping = 1'b1;
                end
                // stream id, first byte is the top one
                if (pos >= id_pos && pos < id_pos + ID_LEN) begin
                    if (stream_id_cfg[(ID_LEN - 1 - (pos - id_pos)) * 8 +: 8] != b)
                        hdr.id_ok = 1'b0;
                end
                // am824 words: label byte dropped, 24-bit sample collected
                if (!hdr.dropping && pos >= data_pos) begin
                    rel  = pos - data_pos;
                    idx  = rel / 4;
                    lane = rel % 4;
                    if (idx < SAMPLES_PER_PACKET) begin
                        if (lane == 0) begin
                            hdr.acc = '0;
                        end else begin
                            hdr.acc = {hdr.acc[15:0], b};
                            if (lane == 3 && hdr.id_ok) begin
                                s.word = {hdr.acc, 8'h00};
                                s.ch   = 1'(idx % CHANNELS);
                                s.fidx = 3'(idx / CHANNELS);
                                s.last = (idx == SAMPLES_PER_PACKET - 1);
                                hit    = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        if (hdr.offset != 7'(OFFSET_LIMIT))
            hdr.offset = hdr.offset + 7'd1;
        if (eof)
            hdr = HDR_CLEAR;
        return hit;
    endfunction

    // lay out one frame in frame_q as {end_of_frame, byte}
    task automatic build_frame(input row_kind_t kind, input int len, input int fill,
                               input bit id_bad);
        bit          vlan;
        int          id_pos;
        int          data_pos;
        int          n;
        int          bad_k;
        logic [15:0] etype;
        logic [15:0] itype;
        logic [7:0]  b;
        vlan     = (kind == ROW_TAGGED || kind == ROW_BAD_INNER);
        id_pos   = vlan ? TAGGED_ID_AT : UNTAGGED_ID_AT;
        data_pos = vlan ? TAGGED_DATA_AT : UNTAGGED_DATA_AT;
        n        = (len > 0) ? len : data_pos + 4 * SAMPLES_PER_PACKET;
        bad_k    = $urandom_range(0, ID_LEN - 1);
        etype    = vlan ? ETH_TYPE_VLAN : ETH_TYPE_AVTP;
        itype    = ETH_TYPE_AVTP;
        // near misses of the two accepted ethertypes
        if (kind == ROW_BAD_OUTER)
            etype = ($urandom_range(0, 1) ? ETH_TYPE_AVTP : ETH_TYPE_VLAN)
                    ^ (16'h1 << $urandom_range(0, 15));
        if (kind == ROW_BAD_INNER)
            itype = ETH_TYPE_AVTP ^ (16'h1 << $urandom_range(0, 15));
        frame_q.delete();
        for (int p = 0; p < n; p++) begin
            b = 8'($urandom);
            if (kind != ROW_NOISE) begin
                if (p == POS_TYPE_HI)
                    b = etype[15:8];
                else if (p == POS_TYPE_LO)
                    b = etype[7:0];
                else if (vlan && p == POS_INNER_HI)
                    b = itype[15:8];
                else if (vlan && p == POS_INNER_LO)
                    b = itype[7:0];
                else if (p >= id_pos && p < id_pos + ID_LEN) begin
                    b = stream_id_cfg[(ID_LEN - 1 - (p - id_pos)) * 8 +: 8];
                    if (id_bad && p - id_pos == bad_k)
                        b = b ^ 8'($urandom_range(1, 255));
                end else if (p >= data_pos && fill >= 0)
                    b = 8'(fill);
            end
            frame_q.push_back({(p == n - 1), b});
        end
    endtask

    // drive frame_q into the block; queue the model's samples if asked
    task automatic send_frame(input bit use_model);
        sample_t s;
        bit      got;
        foreach (frame_q[i]) begin
            if (tx_gaps && $urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            s_valid        <= 1'b1;
            s_data_byte    <= frame_q[i][7:0];
            s_end_of_frame <= frame_q[i][8];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            got = sample_from_byte(frame_q[i][7:0], frame_q[i][8], s);
            if (got && use_model)
                pending_samples.push_back(s);
            bytes_accepted++;
        end
    endtask

    // samples whose values are obvious from the frame contents
    task automatic push_typed(input int n, input logic [31:0] word);
        sample_t s;
        for (int i = 0; i < n; i++) begin
            s.word = word;
            s.ch   = 1'(i % CHANNELS);
            s.fidx = 3'(i / CHANNELS);
            s.last = (i == SAMPLES_PER_PACKET - 1);
            pending_samples.push_back(s);
        end
    endtask

    // stop sending, let every sample come out, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stream_id(input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we        <= 1'b0;
        stream_id_cfg  = v;
    endtask

    task automatic random_frame();
        row_kind_t kind;
        int        r;
        int        len;
        int        fill;
        bit        id_bad;
        r      = $urandom_range(0, 99);
        fill   = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 255 : 0) : -1;
        id_bad = 1'b0;
        len    = 0;
        kind   = $urandom_range(0, 1) ? ROW_TAGGED : ROW_UNTAGGED;
        if (r < 50) begin
            // complete packet
        end else if (r < 62)
            len = (kind == ROW_TAGGED ? TAGGED_DATA_AT : UNTAGGED_DATA_AT)
                  + $urandom_range(0, 4 * SAMPLES_PER_PACKET - 1);
        else if (r < 67)
            len = $urandom_range(1, UNTAGGED_DATA_AT - 1);
        else if (r < 74)
            len = $urandom_range(TAGGED_DATA_AT + 4 * SAMPLES_PER_PACKET, 160);
        else if (r < 80)
            kind = ROW_BAD_OUTER;
        else if (r < 86)
            kind = ROW_BAD_INNER;
        else if (r < 93)
            id_bad = 1'b1;
        else begin
            kind = ROW_NOISE;
            len  = $urandom_range(1, 140);
        end
        build_frame(kind, len, fill, id_bad);
        send_frame(1'b1);
    endtask

    // sample sink with random back-pressure and one long hold on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // compare each output item with the oldest predicted sample
    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sample: word %h ch %0d frame %0d last %0d",
                             m_sample_word, m_channel, m_frame_index, m_last_sample);
            end else begin
                want = pending_samples.pop_front();
                if (m_sample_word !== want.word || m_channel !== want.ch
                        || m_frame_index !== want.fidx || m_last_sample !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("sample mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                 want.word, want.ch, want.fidx, want.last, m_sample_word,
                                 m_channel, m_frame_index, m_last_sample);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [63:0] id_val;
        int          phase_start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // directed frames and register writes
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain();
                write_stream_id(directed_rows[i].cfg_val);
            end else begin
                build_frame(directed_rows[i].kind, directed_rows[i].len,
                            directed_rows[i].fill, directed_rows[i].id_bad);
                if (directed_rows[i].n_exp >= 0)
                    push_typed(directed_rows[i].n_exp, directed_rows[i].word_exp);
                send_frame(directed_rows[i].n_exp < 0);
            end
        end

        // random traffic, one stream id per phase
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                1: id_val = '1;
                2: id_val = '0;
                default: id_val = {$urandom, $urandom};
            endcase
            write_stream_id(id_val);
            // last phase runs at full rate on both sides
            if (ph == 3) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            phase_start = bytes_accepted;
            // long sink stall while a full packet keeps coming
            if (ph == 1) begin
                rx_hold = 1'b1;
                build_frame(ROW_TAGGED, 0, -1, 1'b0);
                send_frame(1'b1);
            end
            while (bytes_accepted - phase_start < PHASE_BYTES)
                random_frame();
        end

        drain();
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
